@@ rtl/mxt_pkg.sv @@
// Shared constants and controller/datapath handshake types for the
// max-XOR-subarray trie core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mxt_pkg;

  localparam int unsigned DATA_BITS_DEF = 32;
  localparam int unsigned MAX_ITEMS_DEF = 1023;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned BEST_W        = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic prep;        // apply start, full check, prefix update
    logic seed_start;  // empty trie, begin inserting zero
    logic q_start;     // begin query walk from the root
    logic q_step;      // one query level
    logic i_start;     // fold query into best, begin insert walk
    logic i_step;      // one insert level (or leaf init)
    logic out_load;    // move result into output register
  } mxt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic seed;
    logic q_last;
    logic i_last;
    logic out_free;
  } mxt_sts_t;

endpackage

`default_nettype wire

@@ rtl/mxt_if.sv @@
// Valid/ready channel interfaces for the trie core input and result items.
// Depends on mxt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mxt_in_if import mxt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               start_req;

  modport source (output valid, output value, output start_req, input ready);
  modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface mxt_out_if import mxt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_xor;
  logic              full_res;

  modport source (output valid, output best_xor, output full_res, input ready);
  modport sink   (input valid, input best_xor, input full_res, output ready);
endinterface

`default_nettype wire

@@ rtl/max_xor_subarray_trie_core.sv @@
// Top level of the max-XOR-subarray trie core: controller plus datapath.
// Depends on mxt_pkg, mxt_if, mxt_ctrl, mxt_datapath.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------
//  in_i    | in  | valid / ready | value[31:0], start_req
//  out_o   | out | valid / ready | best_xor[31:0], full_res
//
// Per item: accept, prep, query walk, insert walk and hand-off; the first
// item of a sequence adds a zero-seed insert walk before the query. A
// refused item goes from prep straight to hand-off. Each walk step visits
// one trie level on the single-read, single-write node store.
// Reset clears prefix, best, item count and node count; the store needs no
// clearing. A result waits in the output register while the next item runs;
// only the hand-off cycle stalls on out_o.ready.
`timescale 1ns / 1ps
`default_nettype none

module max_xor_subarray_trie_core import mxt_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mxt_in_if.sink    in_i,
  mxt_out_if.source out_o
);

  mxt_cmd_t cmd;
  mxt_sts_t sts;

  mxt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mxt_datapath #(
    .DATA_BITS (DATA_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (in_i.value),
    .start_req_i (in_i.start_req),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .best_xor_o  (out_o.best_xor),
    .full_res_o  (out_o.full_res)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after an accept");

  a_one_walk_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.seed_start, cmd.q_start, cmd.i_start, cmd.q_step, cmd.i_step}))
    else $error("more than one walk command at once");

  a_prep_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.prep |-> $past(in_i.valid && in_i.ready))
    else $error("prep without an accepted item");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_o.valid)
    else $error("result loaded but not presented");

endmodule

`default_nettype wire

@@ rtl/mxt_datapath.sv @@
// Datapath: node store, walk registers, prefix/best state and output register.
// Depends on mxt_pkg; driven by mxt_ctrl through mxt_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mxt_datapath import mxt_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mxt_cmd_t           cmd_i,
  output mxt_sts_t                sts_o,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               start_req_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [BEST_W-1:0]       best_xor_o,
  output logic                    full_res_o
);

  localparam int unsigned NODE_CAP = 1 + (MAX_ITEMS + 1) * DATA_BITS;
  localparam int unsigned IDX_W    = $clog2(NODE_CAP);
  localparam int unsigned CNT_W    = $clog2(NODE_CAP + 1);
  localparam int unsigned LVL_W    = $clog2(DATA_BITS);
  localparam int unsigned ITEM_W   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ROW_W    = 2 * IDX_W;

  localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(DATA_BITS - 1);
  localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(NODE_CAP);
  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
  localparam logic [ITEM_W-1:0] ITEM_MAX = ITEM_W'(MAX_ITEMS);
  localparam logic [ITEM_W-1:0] ITEM_ONE = ITEM_W'(1);

  // node store: {child1, child0}, link 0 means no child
  logic [ROW_W-1:0] trie_mem [NODE_CAP];
  logic [ROW_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_data;

  logic [DATA_BITS-1:0] value_q;
  logic                 start_q;
  logic                 full_q;
  logic [ITEM_W-1:0]    item_q;
  logic [DATA_BITS-1:0] prefix_q;
  logic [DATA_BITS-1:0] best_q;
  logic [CNT_W-1:0]     node_cnt_q;
  logic [IDX_W-1:0]     node_q;
  logic [LVL_W-1:0]     lvl_q;
  logic                 leaf_q;
  logic                 fresh_q;
  logic [DATA_BITS-1:0] key_q;
  logic [DATA_BITS-1:0] acc_q;
  logic                 out_valid_q;
  logic [BEST_W-1:0]    out_best_q;
  logic                 out_full_q;

  logic [63:0]          value_ext;
  logic [63:0]          best_ext;
  logic [ITEM_W-1:0]    eff_item;
  logic [DATA_BITS-1:0] base_prefix;
  logic                 kbit;
  logic [IDX_W-1:0]     child0;
  logic [IDX_W-1:0]     child1;
  logic [IDX_W-1:0]     same_c;
  logic [IDX_W-1:0]     other_c;
  logic [IDX_W-1:0]     keep_c;
  logic [IDX_W-1:0]     cnt_idx;
  logic                 cap_hit;
  logic                 alloc;

  assign value_ext   = 64'(value_i);
  assign best_ext    = 64'(best_q);
  assign eff_item    = start_q ? '0 : item_q;
  assign base_prefix = start_q ? '0 : prefix_q;

  assign kbit    = key_q[lvl_q];
  assign child0  = rd_q[IDX_W-1:0];
  assign child1  = rd_q[ROW_W-1:IDX_W];
  assign same_c  = kbit ? child1 : child0;
  assign other_c = kbit ? child0 : child1;
  assign cnt_idx = node_cnt_q[IDX_W-1:0];
  assign cap_hit = (node_cnt_q >= CNT_CAP);
  // a fresh node has no children yet, so its row is never read
  assign alloc   = fresh_q || (same_c == '0);
  assign keep_c  = fresh_q ? '0 : other_c;

  always_comb begin
    sts_o.full     = (eff_item >= ITEM_MAX);
    sts_o.seed     = (eff_item == '0);
    sts_o.q_last   = (lvl_q == '0) || ((other_c == '0) && (same_c == '0));
    sts_o.i_last   = leaf_q || (alloc && cap_hit);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_data = kbit ? {cnt_idx, keep_c} : {keep_c, cnt_idx};
    if (cmd_i.q_step) begin
      rd_addr = (other_c != '0) ? other_c : same_c;
    end
    if (cmd_i.i_step) begin
      if (leaf_q) begin
        wr_en   = fresh_q;
        wr_data = '0;
      end else if (alloc) begin
        wr_en = !cap_hit;
      end else begin
        rd_addr = same_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      trie_mem[node_q] <= wr_data;
    end
    rd_q <= trie_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      prefix_q    <= '0;
      best_q      <= '0;
      node_cnt_q  <= CNT_ONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        if (start_q) begin
          item_q <= '0;
          best_q <= '0;
        end
        prefix_q <= sts_o.full ? base_prefix : (base_prefix ^ value_q);
      end
      if (cmd_i.seed_start) begin
        node_cnt_q <= CNT_ONE;
      end
      if (cmd_i.i_step && !leaf_q && alloc && !cap_hit) begin
        node_cnt_q <= node_cnt_q + CNT_ONE;
      end
      if (cmd_i.i_start) begin
        item_q <= item_q + ITEM_ONE;
        if (acc_q > best_q) begin
          best_q <= acc_q;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_ext[DATA_BITS-1:0];
      start_q <= start_req_i;
    end
    if (cmd_i.prep) begin
      full_q <= sts_o.full;
    end
    if (cmd_i.out_load) begin
      out_best_q <= best_ext[BEST_W-1:0];
      out_full_q <= full_q;
    end
    if (cmd_i.seed_start) begin
      key_q   <= '0;
      node_q  <= '0;
      lvl_q   <= LVL_TOP;
      leaf_q  <= 1'b0;
      fresh_q <= 1'b1;
    end
    if (cmd_i.q_start) begin
      key_q <= prefix_q;
      lvl_q <= LVL_TOP;
      acc_q <= '0;
    end
    if (cmd_i.i_start) begin
      key_q   <= prefix_q;
      node_q  <= '0;
      lvl_q   <= LVL_TOP;
      leaf_q  <= 1'b0;
      fresh_q <= 1'b0;
    end
    if (cmd_i.q_step) begin
      if (other_c != '0) begin
        acc_q[lvl_q] <= 1'b1;
      end
      lvl_q <= lvl_q - LVL_W'(1);
    end
    if (cmd_i.i_step && !leaf_q) begin
      node_q <= alloc ? cnt_idx : same_c;
      if (alloc) begin
        fresh_q <= 1'b1;
      end
      if (lvl_q == '0) begin
        leaf_q <= 1'b1;
      end else begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_xor_o  = out_best_q;
  assign full_res_o  = out_full_q;

endmodule

`default_nettype wire

@@ rtl/mxt_ctrl.sv @@
// Controller FSM: sequences prep, zero seed, query walk, insert walk and
// result hand-off. Depends on mxt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mxt_ctrl import mxt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire mxt_sts_t sts_i,
  output mxt_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SEED   = 3'd2;
  localparam logic [2:0] S_QSTART = 3'd3;
  localparam logic [2:0] S_QUERY  = 3'd4;
  localparam logic [2:0] S_ISTART = 3'd5;
  localparam logic [2:0] S_INSERT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.full) begin
          state_d = S_DONE;
        end else if (sts_i.seed) begin
          cmd_o.seed_start = 1'b1;
          state_d          = S_SEED;
        end else begin
          state_d = S_QSTART;
        end
      end
      S_SEED: begin
        cmd_o.i_step = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_QSTART;
        end
      end
      S_QSTART: begin
        cmd_o.q_start = 1'b1;
        state_d       = S_QUERY;
      end
      S_QUERY: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.q_last) begin
          state_d = S_ISTART;
        end
      end
      S_ISTART: begin
        cmd_o.i_start = 1'b1;
        state_d       = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.i_step = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ bench/mxt_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the max-XOR-subarray trie core: watches the input and result
// channels, predicts each result and checks them in order.
// Depends on mxt_pkg and the mxt_in_if / mxt_out_if interfaces.

module mxt_scoreboard import mxt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mxt_in_if    in_mon,
  mxt_out_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [BEST_W-1:0] best_xor;
    logic              full_res;
  } xor_result_t;

  xor_result_t        best_q[$];
  xor_result_t        exp_r;
  // every prefix of the current sequence seen so far, zero seed included
  logic [VALUE_W-1:0] prefix_set[$];
  logic [VALUE_W-1:0] run_prefix;
  logic [BEST_W-1:0]  best_run;
  int unsigned        seq_len;

  // A full trie walk that takes the opposite child where it can finds the
  // largest XOR against any stored key, so a scan over the stored keys
  // gives the same answer.
  function automatic xor_result_t predict_best(logic [VALUE_W-1:0] v, logic s);
    xor_result_t        r;
    logic [VALUE_W-1:0] hit;
    if (s) begin
      run_prefix = '0;
      best_run   = '0;
      seq_len    = 0;
      prefix_set.delete();
    end
    if (seq_len >= MAX_ITEMS_DEF) begin
      r.best_xor = best_run;
      r.full_res = 1'b1;
      return r;
    end
    if (seq_len == 0) begin
      prefix_set.delete();
      prefix_set.push_back('0);
    end
    run_prefix = run_prefix ^ v;
    hit = '0;
    foreach (prefix_set[k]) begin
      if ((run_prefix ^ prefix_set[k]) > hit) hit = run_prefix ^ prefix_set[k];
    end
    if (hit > best_run) best_run = hit;
    prefix_set.push_back(run_prefix);
    seq_len++;
    r.best_xor = best_run;
    r.full_res = 1'b0;
    return r;
  endfunction

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q.delete();
      prefix_set.delete();
      run_prefix = '0;
      best_run   = '0;
      seq_len    = 0;
      pending_o  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        best_q.push_back(predict_best(in_mon.value, in_mon.start_req));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (best_q.size() == 0) begin
          $display("%0t: unexpected result best_xor %h full_res %b", $time,
                   out_mon.best_xor, out_mon.full_res);
          fail_cnt_o++;
        end else begin
          exp_r = best_q.pop_front();
          if (out_mon.best_xor !== exp_r.best_xor) begin
            $display("%0t: best_xor mismatch: expected %h, actual %h", $time,
                     exp_r.best_xor, out_mon.best_xor);
            fail_cnt_o++;
          end
          if (out_mon.full_res !== exp_r.full_res) begin
            $display("%0t: full_res mismatch: expected %b, actual %b", $time,
                     exp_r.full_res, out_mon.full_res);
            fail_cnt_o++;
          end
        end
      end
      pending_o = best_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the max-XOR-subarray trie core: clock, reset, item
// stimulus, result back-pressure and verdict.
// Depends on mxt_pkg, mxt_if, the core RTL and mxt_scoreboard.

module tb import mxt_pkg::*;;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i;
  logic rst_ni;
  int   send_idle;
  int   recv_idle;
  int   fail_cnt;
  int   pending;
  int   cycle_cnt;

  mxt_in_if  in_bus ();
  mxt_out_if out_bus ();

  max_xor_subarray_trie_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  mxt_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: return w;
      1: return VALUE_W'($urandom_range(15));
      2: return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
      3: return ~(VALUE_W'(1) << $urandom_range(VALUE_W - 1));
      4: return ($urandom_range(1) == 1) ? '1 : '0;
      default: return (w << 16) | VALUE_W'($urandom_range(3));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid stays high into the next item unless a gap is drawn.
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic s);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.value     <= v;
    in_bus.start_req <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly well-formed sequences opened by start_req, with the odd stray
  // restart in the middle.
  task automatic send_sequences(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      for (int k = 0; k < len && sent < n; k++) begin
        send_item(pick_value(), (k == 0) || ($urandom_range(99) < 3));
        sent++;
      end
    end
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.value     = '0;
    in_bus.start_req = 1'b0;
    out_bus.ready    = 1'b0;
    rst_ni           = 1'b0;
    send_idle        = 19;
    recv_idle        = 55;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // first item after reset without start_req: zero seed from reset state
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);
    send_item(32'h5555_5555, 1'b0);
    send_item('1, 1'b1);
    send_item('1, 1'b0);
    send_item(32'h1234_5678, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    send_item(32'h0000_0001, 1'b1);
    send_item('0, 1'b1);
    send_item('0, 1'b0);

    send_sequences(190);
    send_idle = 55;
    recv_idle = 19;
    send_sequences(190);
    send_idle = 0;
    recv_idle = 0;
    send_sequences(150);
    in_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
